// File: rtl/ntfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfsc_pkg
// Shared types, codes and character classes for the text field checker.
// ----------------------------------------------------------------------------
package ntfsc_pkg;

    // Parse phase of the current string
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_NAME  = 3'd1,
        PH_GROUP = 3'd2,
        PH_TAIL  = 3'd3,
        PH_KEY   = 3'd4,
        PH_END   = 3'd5
    } t_phase;

    // Format codes of the format register
    localparam logic [2:0] FMT_NAME    = 3'd0;
    localparam logic [2:0] FMT_IPV4    = 3'd1;
    localparam logic [2:0] FMT_NETWORK = 3'd2;
    localparam logic [2:0] FMT_ENDPT   = 3'd3;
    localparam logic [2:0] FMT_KEY     = 3'd4;

    localparam int KEY_CNT_W = 6;
    localparam logic [KEY_CNT_W-1:0] KEY_CHARS = 6'd43;

    localparam logic [2:0] GROUP_MAX_DIGITS = 3'd3;
    localparam logic [2:0] NET_MAX_DIGITS   = 3'd2;
    localparam logic [2:0] PORT_MAX_DIGITS  = 3'd5;
    localparam logic [1:0] LAST_GROUP       = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_b64(input logic [7:0] c);
        is_b64 = is_letter(c) || is_digit(c) || c == CH_PLUS || c == CH_SLASH;
    endfunction

endpackage

// File: rtl/network_text_field_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_text_field_syntax_checker
// Byte-serial syntax check of interface names, IPv4 addresses, networks,
// endpoints and base64 keys; one verdict request per string terminator.
// ----------------------------------------------------------------------------
//
// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+---------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] = ch
// m_axis    | out | m_axis_tvalid / m_axis_tready | tlast = done_res,
//           |     |                               | tdata[0] = valid_res,
//           |     |                               | tdata[1] = viable
// cfg       | in  | i_cfg_we (no wait)            | i_cfg_wdata = format_select
//
// Throughput: one request per cycle, sustained, as long as m_axis takes.
// Path: a request moves from the input register to the result register
// (input reg -> result reg), and the result is taken from the result register.
// The parse state update is a short compare/increment path, done in the
// cycle the request moves from the input register to the result register.
// Reset (i_rst_n low, synchronous) clears both valid flags and the parse
// state; format_select returns to IPv4.
// A stall on m_axis holds the result; the input register keeps one more
// request, and s_axis_tready drops only when both are full.
//
module network_text_field_syntax_checker
    import ntfsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,   // format_select
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] ch
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic       m_axis_tlast,  // done_res
    output logic [7:0] m_axis_tdata   // [0] valid_res, [1] viable, [7:2] zero
);

    // format register
    logic [2:0]           r_fmt;

    // input stage
    logic                 r_in_valid;
    logic [7:0]           r_in_ch;

    // parse state
    t_phase               r_phase,       n_phase;
    logic [2:0]           r_digit_count, n_digit_count;
    logic [1:0]           r_group_index, n_group_index;
    logic [KEY_CNT_W-1:0] r_key_count,   n_key_count;
    logic                 r_failed,      n_failed;

    // result stage
    logic                 r_out_valid;
    logic                 r_out_last,    n_out_last;
    logic                 r_out_ok,      n_out_ok;
    logic                 r_out_viable,  n_out_viable;

    logic                 out_free;   // result register can take a request
    logic                 fire;       // input register moves to result
    logic                 is_term;
    logic                 step_ok;
    logic                 verdict;
    logic [2:0]           tail_max;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign is_term       = (r_in_ch == CH_NUL);
    assign tail_max      = (r_fmt == FMT_NETWORK) ? NET_MAX_DIGITS : PORT_MAX_DIGITS;

    // ------------------------------------------------------------------
    // Next parse state
    // ------------------------------------------------------------------
    always_comb begin
        n_phase       = r_phase;
        n_digit_count = r_digit_count;
        n_group_index = r_group_index;
        n_key_count   = r_key_count;
        n_failed      = r_failed;
        step_ok       = 1'b0;

        if (is_term) begin
            // string done: back to start of string
            n_phase       = PH_START;
            n_digit_count = '0;
            n_group_index = '0;
            n_key_count   = '0;
            n_failed      = 1'b0;
        end else if (!r_failed) begin
            unique case (r_phase)
                PH_START: begin
                    if (r_fmt == FMT_NAME && is_letter(r_in_ch)) begin
                        n_phase = PH_NAME;
                        step_ok = 1'b1;
                    end else if ((r_fmt == FMT_IPV4 || r_fmt == FMT_NETWORK ||
                                  r_fmt == FMT_ENDPT) && is_digit(r_in_ch)) begin
                        n_phase       = PH_GROUP;
                        n_digit_count = 3'd1;
                        n_group_index = '0;
                        step_ok       = 1'b1;
                    end else if (r_fmt == FMT_KEY && is_b64(r_in_ch)) begin
                        n_phase     = PH_KEY;
                        n_key_count = KEY_CNT_W'(1);
                        step_ok     = 1'b1;
                    end
                end
                PH_NAME: begin
                    step_ok = is_letter(r_in_ch) || is_digit(r_in_ch) ||
                              r_in_ch == CH_DASH || r_in_ch == CH_AT;
                end
                PH_GROUP: begin
                    if (is_digit(r_in_ch)) begin
                        if (r_digit_count < GROUP_MAX_DIGITS) begin
                            n_digit_count = r_digit_count + 3'd1;
                            step_ok       = 1'b1;
                        end
                    end else if (r_digit_count != '0) begin
                        if (r_in_ch == CH_DOT) begin
                            if (r_group_index != LAST_GROUP) begin
                                n_group_index = r_group_index + 2'd1;
                                n_digit_count = '0;
                                step_ok       = 1'b1;
                            end
                        end else if (r_group_index == LAST_GROUP &&
                                     ((r_fmt == FMT_NETWORK && r_in_ch == CH_SLASH) ||
                                      (r_fmt == FMT_ENDPT && r_in_ch == CH_COLON))) begin
                            n_phase       = PH_TAIL;
                            n_digit_count = '0;
                            step_ok       = 1'b1;
                        end
                    end
                end
                PH_TAIL: begin
                    if (is_digit(r_in_ch) && r_digit_count < tail_max) begin
                        n_digit_count = r_digit_count + 3'd1;
                        step_ok       = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (r_key_count < KEY_CHARS) begin
                        if (is_b64(r_in_ch)) begin
                            n_key_count = r_key_count + KEY_CNT_W'(1);
                            step_ok     = 1'b1;
                        end
                    end else if (r_in_ch == CH_EQ) begin
                        n_phase = PH_END;
                        step_ok = 1'b1;
                    end
                end
                default: begin
                    // complete, or an unused code: only the terminator fits
                    step_ok = 1'b0;
                end
            endcase
            n_failed = !step_ok;
        end
    end

    // ------------------------------------------------------------------
    // Result fields
    // ------------------------------------------------------------------
    always_comb begin
        verdict = 1'b0;
        unique case (r_phase)
            PH_NAME:  verdict = 1'b1;
            PH_GROUP: verdict = (r_fmt == FMT_IPV4) && (r_group_index == LAST_GROUP) &&
                                (r_digit_count != '0);
            PH_TAIL:  verdict = (r_digit_count != '0);
            PH_END:   verdict = 1'b1;
            default:  verdict = 1'b0;
        endcase
        verdict = verdict && !r_failed;

        n_out_last   = is_term;
        n_out_ok     = is_term && verdict;
        n_out_viable = is_term ? verdict : !n_failed;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt         <= FMT_IPV4;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_START;
            r_digit_count <= '0;
            r_group_index <= '0;
            r_key_count   <= '0;
            r_failed      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_phase       <= n_phase;
                r_digit_count <= n_digit_count;
                r_group_index <= n_group_index;
                r_key_count   <= n_key_count;
                r_failed      <= n_failed;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ch <= s_axis_tdata;
        end
        if (fire) begin
            r_out_last   <= n_out_last;
            r_out_ok     <= n_out_ok;
            r_out_viable <= n_out_viable;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {6'd0, r_out_viable, r_out_ok};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // valid_res only on the terminator
    a_ok_only_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !m_axis_tdata[0])
        else $error("valid_res set on a non-terminator");

    // on the terminator viable mirrors the verdict
    a_term_viable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[0] == m_axis_tdata[1]))
        else $error("viable differs from verdict on terminator");

    // terminator returns the parser to start of string
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_term) |=> (r_phase == PH_START && r_key_count == '0 &&
                               r_group_index == '0 && !r_failed))
        else $error("parse state not cleared after terminator");

    // once failed, later characters are not viable
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_failed && !is_term) |=> (r_failed && !r_out_viable))
        else $error("failed string reported viable");

    // key counter never passes the key length
    a_key_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KEY_CHARS)
        else $error("key counter overflow");
`endif

endmodule
